// ===== rtl/core/crsf_rx_pkg.sv =====
package crsf_rx_pkg;

   localparam logic [7:0]  CRC_POLY      = 8'hD5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1100;
   localparam logic [7:0]  LENGTH_BIAS   = 8'd2;

   typedef enum logic [1:0] {
      PH_WAIT_NEXT   = 2'd0,
      PH_WAIT_LENGTH = 2'd1,
      PH_WAIT_TYPE   = 2'd2,
      PH_WAIT_DATA   = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_IGNORED = 3'd0,
      ST_START   = 3'd1,
      ST_LENGTH  = 3'd2,
      ST_TYPE    = 3'd3,
      ST_PAYLOAD = 3'd4,
      ST_GOOD    = 3'd5,
      ST_BAD     = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [31:0] arrival_time_us;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data_byte;
      logic [7:0]  byte_index;
      logic [7:0]  frame_kind;
      logic [7:0]  payload_count;
      logic [31:0] frame_interval_us;
      logic [15:0] bad_frame_count;
   } rsp_item_type;

   // one CRC-8 byte step, MSB first
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

// ===== rtl/core/crsf_rx_if.sv =====
interface crsf_rx_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  rx_byte;
   logic [31:0] arrival_time_us;

   modport source (output valid, rx_byte, arrival_time_us, input ready);
   modport sink   (input valid, rx_byte, arrival_time_us, output ready);
endinterface

interface crsf_rx_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  data_byte;
   logic [7:0]  byte_index;
   logic [7:0]  frame_kind;
   logic [7:0]  payload_count;
   logic [31:0] frame_interval_us;
   logic [15:0] bad_frame_count;

   modport source (output valid, status, data_byte, byte_index, frame_kind, payload_count,
                   frame_interval_us, bad_frame_count, input ready);
   modport sink   (input valid, status, data_byte, byte_index, frame_kind, payload_count,
                   frame_interval_us, bad_frame_count, output ready);
endinterface

// ===== rtl/core/crsf_rx_parser.sv =====
module crsf_rx_parser
   import crsf_rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  req_item_type item,
   input  logic [15:0]  timeout_us,
   output rsp_item_type result
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  position_ff, position_in;
   logic [7:0]  kind_ff, kind_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] last_end_ff, last_end_in;
   logic [15:0] errors_ff, errors_in;

   logic [31:0] since_start;
   logic        timed_out;

   assign since_start = item.arrival_time_us - start_ff;
   assign timed_out   = since_start > {16'd0, timeout_us};

   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      length_in   = length_ff;
      position_in = position_ff;
      kind_in     = kind_ff;
      start_in    = start_ff;
      last_end_in = last_end_ff;
      errors_in   = errors_ff;

      result                   = '0;
      result.status            = ST_IGNORED;

      if (timed_out) begin
         start_in         = item.arrival_time_us;
         phase_in         = PH_WAIT_LENGTH;
         result.status    = ST_START;
         result.data_byte = item.rx_byte;
      end else begin
         case (phase_ff)
            PH_WAIT_LENGTH: begin
               length_in     = item.rx_byte - LENGTH_BIAS;
               phase_in      = PH_WAIT_TYPE;
               result.status = ST_LENGTH;
            end
            PH_WAIT_TYPE: begin
               kind_in       = item.rx_byte;
               position_in   = '0;
               crc_in        = crc_step(8'd0, item.rx_byte);
               phase_in      = PH_WAIT_DATA;
               result.status = ST_TYPE;
            end
            PH_WAIT_DATA: begin
               if (position_ff < length_ff) begin
                  result.status     = ST_PAYLOAD;
                  result.data_byte  = item.rx_byte;
                  result.byte_index = position_ff;
                  crc_in            = crc_step(crc_ff, item.rx_byte);
                  position_in       = position_ff + 8'd1;
               end else begin
                  result.frame_interval_us = item.arrival_time_us - last_end_ff;
                  last_end_in              = item.arrival_time_us;
                  if (item.rx_byte == crc_ff) begin
                     result.status = ST_GOOD;
                  end else begin
                     result.status = ST_BAD;
                     // saturate the bad-frame tally
                     if (errors_ff != '1) begin
                        errors_in = errors_ff + 16'd1;
                     end
                  end
                  phase_in = PH_WAIT_NEXT;
               end
            end
            default: begin
               phase_in = PH_WAIT_NEXT;
            end
         endcase
      end

      result.frame_kind      = kind_in;
      result.payload_count   = length_in;
      result.bad_frame_count = errors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_WAIT_NEXT;
         crc_ff      <= '0;
         length_ff   <= '0;
         position_ff <= '0;
         kind_ff     <= '0;
         start_ff    <= '0;
         last_end_ff <= '0;
         errors_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         crc_ff      <= crc_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         kind_ff     <= kind_in;
         start_ff    <= start_in;
         last_end_ff <= last_end_in;
         errors_ff   <= errors_in;
      end
   end

endmodule

// ===== rtl/core/crsf_frame_receiver_core.sv =====
// Channel    Port       Direction  Contents
// request    req_chan   in         rx_byte, arrival_time_us
// response   rsp_chan   out        status, data_byte, byte_index, frame_kind,
//                                  payload_count, frame_interval_us, bad_frame_count
// control    csr_*      in         frame_timeout_us write
//
// Each item passes an input register, the parse and CRC logic, and a result register;
// one item per cycle is sustained while the response channel is ready.
// Frame state advances as the item moves from the input register to the result register.
// A stalled result register holds the input register, which still takes a new item
// whenever its own item moves on. Synchronous active-high reset clears frame state,
// both valid flags and sets the timeout to 1100 us.
module crsf_frame_receiver_core
   import crsf_rx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   crsf_rx_req_if.sink         req_chan,
   crsf_rx_rsp_if.source       rsp_chan,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   logic [15:0]  timeout_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         advance;
   logic         accept;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.rx_byte         <= req_chan.rx_byte;
         in_item_ff.arrival_time_us <= req_chan.arrival_time_us;
      end
   end

   crsf_rx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .timeout_us (timeout_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.status            = out_item_ff.status;
   assign rsp_chan.data_byte         = out_item_ff.data_byte;
   assign rsp_chan.byte_index        = out_item_ff.byte_index;
   assign rsp_chan.frame_kind        = out_item_ff.frame_kind;
   assign rsp_chan.payload_count     = out_item_ff.payload_count;
   assign rsp_chan.frame_interval_us = out_item_ff.frame_interval_us;
   assign rsp_chan.bad_frame_count   = out_item_ff.bad_frame_count;

endmodule
